>>> hw/rtl/i2crb_pkg.sv
// ============================================================================
// i2crb_pkg
// Shared types and constants for the I2C register burst master.
// ============================================================================
package i2crb_pkg;

    // Default depth of the write byte buffer
    localparam int unsigned DEF_BUFFER_DEPTH = 16;

    // Field widths
    localparam int unsigned FUNC_W     = 2;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned LEN_W      = 5;
    localparam int unsigned DEV_ADDR_W = 7;
    localparam int unsigned PT_W       = 10;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 10;

    // Reset values of the configuration registers
    localparam logic [DEV_ADDR_W-1:0] DEV_ADDR_RESET    = 7'd104;
    localparam logic [PT_W-1:0]       PHASE_TICKS_RESET = 10'd10;

    // Top bit of a shifted byte, driven onto SDA
    localparam logic [BYTE_W-1:0] MSB_MASK = 8'h80;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_QUEUE = 2'd1,
        FUNC_WRITE = 2'd2,
        FUNC_READ  = 2'd3
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEV_ADDR    = 2'd0,
        CFG_PHASE_TICKS = 2'd1
    } cfg_idx_t;

    // One input request
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [BYTE_W-1:0] reg_addr;
        logic [LEN_W-1:0]  length;
        logic [BYTE_W-1:0] write_byte;
        logic              sda_in;
    } cmd_t;

    // One result request
    typedef struct packed {
        logic              scl;
        logic              sda_release;
        logic              busy_res;
        logic              read_valid;
        logic [BYTE_W-1:0] read_data;
        logic              done_res;
        logic              nack_error;
    } res_t;

    // Sequencer status
    typedef struct packed {
        logic busy;
    } seq_stat_t;

endpackage

>>> hw/rtl/i2crb_if.sv
// ============================================================================
// i2crb_if
// Valid/ready channels for input and result requests.
// ============================================================================
interface i2crb_cmd_if
    import i2crb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] reg_addr;
    logic [LEN_W-1:0]  length;
    logic [BYTE_W-1:0] write_byte;
    logic              sda_in;

    modport source (output valid, func, reg_addr, length, write_byte, sda_in,
                    input ready);
    modport sink (input valid, func, reg_addr, length, write_byte, sda_in,
                  output ready);
endinterface

interface i2crb_rsp_if
    import i2crb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              scl;
    logic              sda_release;
    logic              busy_res;
    logic              read_valid;
    logic [BYTE_W-1:0] read_data;
    logic              done_res;
    logic              nack_error;

    modport source (output valid, scl, sda_release, busy_res, read_valid, read_data,
                    done_res, nack_error, input ready);
    modport sink (input valid, scl, sda_release, busy_res, read_valid, read_data,
                  done_res, nack_error, output ready);
endinterface

>>> hw/rtl/i2crb_buf.sv
// ============================================================================
// i2crb_buf
// Write byte buffer: one write port, one read port, registered read data.
// ============================================================================
module i2crb_buf
    import i2crb_pkg::*;
#(
    parameter int unsigned BUFFER_DEPTH = DEF_BUFFER_DEPTH,
    localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [BYTE_W-1:0] wr_data,
    input  logic [AW-1:0]     rd_addr,
    output logic [BYTE_W-1:0] rd_data
);

    logic [BYTE_W-1:0] mem [BUFFER_DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/i2crb_seq.sv
// ============================================================================
// i2crb_seq
// Bus sequencer: one tick per accepted request, config registers, queueing.
// ============================================================================
module i2crb_seq
    import i2crb_pkg::*;
#(
    parameter int unsigned BUFFER_DEPTH = DEF_BUFFER_DEPTH,
    localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  cmd_fire,
    input  cmd_t                  cmd_in,
    output logic                  buf_wr_en,
    output logic [AW-1:0]         buf_wr_addr,
    output logic [BYTE_W-1:0]     buf_wr_data,
    output logic [AW-1:0]         buf_rd_addr,
    input  logic [BYTE_W-1:0]     buf_rd_data,
    output res_t                  res,
    output seq_stat_t             stat
);

    localparam int unsigned QW = $clog2(BUFFER_DEPTH + 1);
    localparam int unsigned CW = (QW > LEN_W) ? QW : LEN_W;

    localparam logic [1:0] SLOT_LOW0 = 2'd0;
    localparam logic [1:0] SLOT_HIGH = 2'd1;
    localparam logic [1:0] SLOT_LOW1 = 2'd2;
    localparam logic [2:0] BIT_LAST  = 3'd7;

    typedef enum logic [13:0] {
        ST_IDLE      = 14'h0001,
        ST_START     = 14'h0002,
        ST_ADDRW_BIT = 14'h0004,
        ST_ADDRW_ACK = 14'h0008,
        ST_REG_BIT   = 14'h0010,
        ST_REG_ACK   = 14'h0020,
        ST_WDATA_BIT = 14'h0040,
        ST_WDATA_ACK = 14'h0080,
        ST_RSTART    = 14'h0100,
        ST_RADDR_BIT = 14'h0200,
        ST_RADDR_ACK = 14'h0400,
        ST_RDATA_BIT = 14'h0800,
        ST_RDATA_ACK = 14'h1000,
        ST_STOP      = 14'h2000
    } step_t;

    logic [DEV_ADDR_W-1:0] dev_addr_reg;
    logic [PT_W-1:0]       phase_ticks_reg;

    step_t             step_reg, step_next;
    logic [PT_W-1:0]   phase_reg, phase_next;
    logic [1:0]        slot_reg, slot_next;
    logic [2:0]        bit_reg, bit_next;
    logic [BYTE_W-1:0] shift_reg, shift_next;
    logic [LEN_W-1:0]  bc_reg, bc_next;
    logic [LEN_W-1:0]  tl_reg, tl_next;
    logic [BYTE_W-1:0] reg_latch_reg, reg_latch_next;
    logic              read_mode_reg, read_mode_next;
    logic [QW-1:0]     queued_reg, queued_next;
    logic              ack_reg, ack_next;
    logic              err_reg, err_next;

    logic [PT_W-1:0]   pt;
    logic [PT_W:0]     phase_inc;
    logic [LEN_W-1:0]  bc_inc;
    logic [LEN_W:0]    bc_inc_wide;
    logic [CW-1:0]     rd_wide;
    logic              is_read;
    logic              scl_o;
    logic              sda_o;
    logic              rvalid;
    logic [BYTE_W-1:0] rdata;
    logic              done;
    logic              nerr;

    // Configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg    <= DEV_ADDR_RESET;
            phase_ticks_reg <= PHASE_TICKS_RESET;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == CFG_DEV_ADDR)
            begin
                dev_addr_reg <= cfg_wdata[DEV_ADDR_W-1:0];
            end
            else if (cfg_index == CFG_PHASE_TICKS)
            begin
                phase_ticks_reg <= cfg_wdata[PT_W-1:0];
            end
        end
    end

    assign pt          = (phase_ticks_reg == '0) ? PT_W'(1) : phase_ticks_reg;
    assign phase_inc   = {1'b0, phase_reg} + (PT_W + 1)'(1);
    assign bc_inc      = bc_reg + LEN_W'(1);
    assign bc_inc_wide = {1'b0, bc_reg} + (LEN_W + 1)'(1);
    assign is_read     = (cmd_in.func == FUNC_READ);

    // Prefetch the next data byte: entry bc during the register ack slot,
    // entry bc+1 during a data ack slot.
    assign rd_wide     = (step_reg == ST_WDATA_ACK) ? CW'(bc_inc) : CW'(bc_reg);
    assign buf_rd_addr = rd_wide[AW-1:0];
    assign buf_wr_addr = queued_reg[AW-1:0];
    assign buf_wr_data = cmd_in.write_byte;

    // Line drive for the phase current at the start of the tick
    always_comb
    begin
        scl_o = 1'b1;
        sda_o = 1'b1;
        case (step_reg)
            ST_START, ST_RSTART:
            begin
                scl_o = (slot_reg != SLOT_LOW1);
                sda_o = (slot_reg == SLOT_LOW0);
            end
            ST_ADDRW_BIT, ST_REG_BIT, ST_WDATA_BIT, ST_RADDR_BIT:
            begin
                scl_o = (slot_reg == SLOT_HIGH);
                sda_o = ((shift_reg & MSB_MASK) != '0);
            end
            ST_ADDRW_ACK, ST_REG_ACK, ST_WDATA_ACK, ST_RADDR_ACK, ST_RDATA_BIT:
            begin
                scl_o = (slot_reg == SLOT_HIGH);
                sda_o = 1'b1;
            end
            ST_RDATA_ACK:
            begin
                scl_o = (slot_reg == SLOT_HIGH);
                sda_o = !(bc_inc_wide < {1'b0, tl_reg});
            end
            ST_STOP:
            begin
                scl_o = (slot_reg != SLOT_LOW0);
                sda_o = (slot_reg == SLOT_LOW1);
            end
            default:
            begin
                scl_o = 1'b1;
                sda_o = 1'b1;
            end
        endcase
    end

    // Tick update
    always_comb
    begin
        step_next      = step_reg;
        phase_next     = phase_reg;
        slot_next      = slot_reg;
        bit_next       = bit_reg;
        shift_next     = shift_reg;
        bc_next        = bc_reg;
        tl_next        = tl_reg;
        reg_latch_next = reg_latch_reg;
        read_mode_next = read_mode_reg;
        queued_next    = queued_reg;
        ack_next       = ack_reg;
        err_next       = err_reg;
        buf_wr_en      = 1'b0;
        rvalid         = 1'b0;
        rdata          = '0;
        done           = 1'b0;
        nerr           = 1'b0;

        if (cmd_fire)
        begin
            if (step_reg == ST_IDLE)
            begin
                phase_next = '0;
                slot_next  = SLOT_LOW0;
                if (cmd_in.func == FUNC_QUEUE)
                begin
                    if (queued_reg < QW'(BUFFER_DEPTH))
                    begin
                        buf_wr_en   = 1'b1;
                        queued_next = queued_reg + QW'(1);
                    end
                end
                else if (cmd_in.func == FUNC_WRITE || cmd_in.func == FUNC_READ)
                begin
                    reg_latch_next = cmd_in.reg_addr;
                    read_mode_next = is_read;
                    if (!is_read && (CW'(cmd_in.length) > CW'(BUFFER_DEPTH)))
                    begin
                        tl_next = LEN_W'(BUFFER_DEPTH);
                    end
                    else
                    begin
                        tl_next = cmd_in.length;
                    end
                    bc_next     = '0;
                    bit_next    = '0;
                    shift_next  = '0;
                    ack_next    = 1'b0;
                    err_next    = 1'b0;
                    queued_next = '0;
                    step_next   = ST_START;
                end
            end
            else if (phase_inc < {1'b0, pt})
            begin
                phase_next = phase_reg + PT_W'(1);
            end
            else
            begin
                phase_next = '0;
                // Sample SDA at the end of SCL high
                if (slot_reg == SLOT_HIGH)
                begin
                    if (step_reg == ST_ADDRW_ACK || step_reg == ST_REG_ACK ||
                        step_reg == ST_WDATA_ACK || step_reg == ST_RADDR_ACK)
                    begin
                        ack_next = cmd_in.sda_in;
                    end
                    if (step_reg == ST_RDATA_BIT)
                    begin
                        shift_next = {shift_reg[BYTE_W-2:0], cmd_in.sda_in};
                        if (bit_reg == BIT_LAST)
                        begin
                            rvalid = 1'b1;
                            rdata  = shift_next;
                        end
                    end
                end
                if (slot_reg != SLOT_LOW1)
                begin
                    slot_next = slot_reg + 2'd1;
                end
                else
                begin
                    slot_next = SLOT_LOW0;
                    case (step_reg)
                        ST_START:
                        begin
                            shift_next = {dev_addr_reg, 1'b0};
                            bit_next   = '0;
                            step_next  = ST_ADDRW_BIT;
                        end
                        ST_RSTART:
                        begin
                            shift_next = {dev_addr_reg, 1'b1};
                            bit_next   = '0;
                            step_next  = ST_RADDR_BIT;
                        end
                        ST_ADDRW_BIT, ST_REG_BIT, ST_WDATA_BIT, ST_RADDR_BIT:
                        begin
                            if (bit_reg == BIT_LAST)
                            begin
                                bit_next = '0;
                                case (step_reg)
                                    ST_ADDRW_BIT: step_next = ST_ADDRW_ACK;
                                    ST_REG_BIT:   step_next = ST_REG_ACK;
                                    ST_WDATA_BIT: step_next = ST_WDATA_ACK;
                                    default:      step_next = ST_RADDR_ACK;
                                endcase
                            end
                            else
                            begin
                                bit_next   = bit_reg + 3'd1;
                                shift_next = {shift_reg[BYTE_W-2:0], 1'b0};
                            end
                        end
                        ST_RDATA_BIT:
                        begin
                            if (bit_reg == BIT_LAST)
                            begin
                                bit_next  = '0;
                                step_next = ST_RDATA_ACK;
                            end
                            else
                            begin
                                bit_next = bit_reg + 3'd1;
                            end
                        end
                        ST_ADDRW_ACK:
                        begin
                            if (ack_reg)
                            begin
                                err_next  = 1'b1;
                                step_next = ST_STOP;
                            end
                            else
                            begin
                                shift_next = reg_latch_reg;
                                step_next  = ST_REG_BIT;
                            end
                        end
                        ST_REG_ACK:
                        begin
                            // Register byte NACK is ignored
                            if (read_mode_reg)
                            begin
                                step_next = ST_RSTART;
                            end
                            else if (bc_reg < tl_reg)
                            begin
                                shift_next = buf_rd_data;
                                step_next  = ST_WDATA_BIT;
                            end
                            else
                            begin
                                step_next = ST_STOP;
                            end
                        end
                        ST_WDATA_ACK:
                        begin
                            if (ack_reg)
                            begin
                                err_next  = 1'b1;
                                step_next = ST_STOP;
                            end
                            else
                            begin
                                bc_next = bc_inc;
                                if (bc_inc < tl_reg)
                                begin
                                    shift_next = buf_rd_data;
                                    step_next  = ST_WDATA_BIT;
                                end
                                else
                                begin
                                    step_next = ST_STOP;
                                end
                            end
                        end
                        ST_RADDR_ACK:
                        begin
                            if (ack_reg)
                            begin
                                err_next  = 1'b1;
                                step_next = ST_STOP;
                            end
                            else if (tl_reg != '0)
                            begin
                                shift_next = '0;
                                step_next  = ST_RDATA_BIT;
                            end
                            else
                            begin
                                step_next = ST_STOP;
                            end
                        end
                        ST_RDATA_ACK:
                        begin
                            bc_next = bc_inc;
                            if (bc_inc < tl_reg)
                            begin
                                shift_next = '0;
                                step_next  = ST_RDATA_BIT;
                            end
                            else
                            begin
                                step_next = ST_STOP;
                            end
                        end
                        ST_STOP:
                        begin
                            step_next = ST_IDLE;
                            done      = 1'b1;
                            nerr      = err_reg;
                            err_next  = 1'b0;
                        end
                        default:
                        begin
                            step_next = ST_IDLE;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= ST_IDLE;
            phase_reg     <= '0;
            slot_reg      <= SLOT_LOW0;
            bit_reg       <= '0;
            shift_reg     <= '0;
            bc_reg        <= '0;
            tl_reg        <= '0;
            reg_latch_reg <= '0;
            read_mode_reg <= 1'b0;
            queued_reg    <= '0;
            ack_reg       <= 1'b0;
            err_reg       <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            phase_reg     <= phase_next;
            slot_reg      <= slot_next;
            bit_reg       <= bit_next;
            shift_reg     <= shift_next;
            bc_reg        <= bc_next;
            tl_reg        <= tl_next;
            reg_latch_reg <= reg_latch_next;
            read_mode_reg <= read_mode_next;
            queued_reg    <= queued_next;
            ack_reg       <= ack_next;
            err_reg       <= err_next;
        end
    end

    always_comb
    begin
        res.scl         = scl_o;
        res.sda_release = sda_o;
        res.busy_res    = (step_reg != ST_IDLE);
        res.read_valid  = rvalid;
        res.read_data   = rdata;
        res.done_res    = done;
        res.nack_error  = nerr;
    end

    assign stat.busy = (step_reg != ST_IDLE);

endmodule

>>> hw/rtl/i2crb_oq.sv
// ============================================================================
// i2crb_oq
// Two-entry result queue; keeps input flowing while the sink stalls, until both entries are held.
// ============================================================================
module i2crb_oq
    import i2crb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  res_t push_data,
    output logic not_full,
    input  logic pop,
    output logic head_valid,
    output res_t head_data
);

    localparam logic [1:0] CNT_EMPTY = 2'd0;
    localparam logic [1:0] CNT_ONE   = 2'd1;
    localparam logic [1:0] CNT_FULL  = 2'd2;

    logic [1:0] cnt_reg, cnt_next;
    res_t       head_reg, head_next;
    res_t       tail_reg, tail_next;

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg + 2'(push) - 2'(pop);
        case (cnt_reg)
            CNT_EMPTY:
            begin
                if (push)
                begin
                    head_next = push_data;
                end
            end
            CNT_ONE:
            begin
                if (push && pop)
                begin
                    head_next = push_data;
                end
                else if (push)
                begin
                    tail_next = push_data;
                end
            end
            CNT_FULL:
            begin
                if (pop)
                begin
                    head_next = tail_reg;
                end
            end
            default:
            begin
                head_next = head_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= CNT_EMPTY;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign not_full   = (cnt_reg != CNT_FULL);
    assign head_valid = (cnt_reg != CNT_EMPTY);
    assign head_data  = head_reg;

endmodule

>>> hw/rtl/i2c_register_burst_master_unit.sv
// ============================================================================
// i2c_register_burst_master_unit
// Bit-banged I2C master for register write and read bursts.
// ============================================================================
// Usage:
//  - cmd carries one bus tick per request: queue a write byte while idle,
//    start a write or read burst, or just tick. sda_in is the sampled line.
//  - rsp returns exactly one result request per cmd request: SCL/SDA drive,
//    busy, received byte with its strobe, done and NACK error.
//  - cfg_wr_en/cfg_index/cfg_wdata set device address (0) and phase length
//    (1); write them only while the block is idle.
//  - Throughput: one request per clock while the result queue has room. The
//    result is registered in the result queue; the sequencer state is
//    registered and the data byte is prefetched from the buffer's synchronous
//    read port during the register and write data acknowledge slots.
//  - Reset: sequencer idle, queue empty, address 104, phase length 10 ticks.
//    Buffer contents are undefined until queued.
//  - Stall: a two-entry result queue absorbs a stalled sink; cmd.ready drops
//    only when both entries are held.
// ============================================================================
module i2c_register_burst_master_unit
    import i2crb_pkg::*;
#(
    parameter int unsigned BUFFER_DEPTH = DEF_BUFFER_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    i2crb_cmd_if.sink             cmd,
    i2crb_rsp_if.source           rsp
);

    localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    cmd_t              cmd_in;
    logic              cmd_fire;
    logic              oq_not_full;
    res_t              res;
    res_t              head;
    seq_stat_t         stat;
    logic              buf_wr_en;
    logic [AW-1:0]     buf_wr_addr;
    logic [BYTE_W-1:0] buf_wr_data;
    logic [AW-1:0]     buf_rd_addr;
    logic [BYTE_W-1:0] buf_rd_data;

    // Input request fields
    always_comb
    begin
        cmd_in.func       = cmd.func;
        cmd_in.reg_addr   = cmd.reg_addr;
        cmd_in.length     = cmd.length;
        cmd_in.write_byte = cmd.write_byte;
        cmd_in.sda_in     = cmd.sda_in;
    end

    // Take a request whenever the result queue has room
    assign cmd.ready = oq_not_full;
    assign cmd_fire  = cmd.valid && oq_not_full;

    // Data byte buffer
    i2crb_buf #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_buf (
        .clk     (clk),
        .wr_en   (buf_wr_en),
        .wr_addr (buf_wr_addr),
        .wr_data (buf_wr_data),
        .rd_addr (buf_rd_addr),
        .rd_data (buf_rd_data)
    );

    // Bus sequencer, one tick per request
    i2crb_seq #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .cmd_fire    (cmd_fire),
        .cmd_in      (cmd_in),
        .buf_wr_en   (buf_wr_en),
        .buf_wr_addr (buf_wr_addr),
        .buf_wr_data (buf_wr_data),
        .buf_rd_addr (buf_rd_addr),
        .buf_rd_data (buf_rd_data),
        .res         (res),
        .stat        (stat)
    );

    // Result queue
    i2crb_oq u_oq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (cmd_fire),
        .push_data  (res),
        .not_full   (oq_not_full),
        .pop        (rsp.valid && rsp.ready),
        .head_valid (rsp.valid),
        .head_data  (head)
    );

    assign rsp.scl         = head.scl;
    assign rsp.sda_release = head.sda_release;
    assign rsp.busy_res    = head.busy_res;
    assign rsp.read_valid  = head.read_valid;
    assign rsp.read_data   = head.read_data;
    assign rsp.done_res    = head.done_res;
    assign rsp.nack_error  = head.nack_error;

`ifndef SYNTHESIS
    // Stop completion returns the sequencer to idle
    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && res.done_res) |=> !stat.busy)
        else $error("sequencer still busy after done");

    // A NACK error is only flagged on the done tick
    a_nack_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && res.nack_error) |-> res.done_res)
        else $error("nack_error without done_res");

    // A start taken while idle launches a transaction
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && !stat.busy &&
         (cmd_in.func == FUNC_WRITE || cmd_in.func == FUNC_READ)) |=> stat.busy)
        else $error("start request did not make the sequencer busy");
`endif

endmodule
